>>> design/revision_chain_delta_journal_defines.svh
// Assertion macros used by the revision chain journal design file.
`ifndef REVISION_CHAIN_DELTA_JOURNAL_DEFINES_SVH
`define REVISION_CHAIN_DELTA_JOURNAL_DEFINES_SVH

// Checks a property at each rising clock edge while reset is released.
`define RCDJ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("journal assertion failed");

// Checks a property at each rising clock edge, reset included.
`define RCDJ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("journal assertion failed");

`endif

>>> design/rcdj_pkg.sv
// Types and constants of the revision chain journal.
package rcdj_pkg;

  localparam int unsigned NumSlots = 64;
  localparam int unsigned SlotW    = $clog2(NumSlots);
  localparam int unsigned CountW   = SlotW + 1;
  localparam int unsigned GapDepth = 64;

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_LATEST = 3'd1,
    REQ_NEXT   = 3'd2,
    REQ_PRUNE  = 3'd3,
    REQ_SNAP   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOINIT   = 3'd1,
    ST_BADARG   = 3'd2,
    ST_BADSTATE = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_RANGE    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_LINK
  } fsm_e;

  typedef struct packed {
    logic [31:0] chunk_x;
    logic [31:0] chunk_z;
    logic [63:0] revision;
    logic [63:0] prior;
    logic [31:0] world;
    logic [63:0] data;
  } rec_t;

endpackage

>>> design/revision_chain_delta_journal.sv
// Revision chain journal: record store, scan sequencer and request logic.
//
//  channel   | signals                                  | direction
//  request   | start_i, busy_o, req_type_i .. change_data_i | in, busy_o out
//  result    | done_o, status_o .. retained_o           | out, one cycle strobe
//  config    | cfg_valid_i, cfg_ready_o, cfg_capacity_i | in, cfg_ready_o out
//
// Latest and next record take one pass over the stored records.
// Append and prune take the same; snapshot check takes up to two passes, scan then link.
// Refused or uninitialized requests answer in the cycle after they are taken, with no pass.
// The single record memory port bounds each pass to one entry per cycle.
// Reset clears count and capacity; the record memory is not cleared.
// The result receiver cannot stall; a result is shown for one cycle only.
`include "revision_chain_delta_journal_defines.svh"

module revision_chain_delta_journal #(
  parameter int unsigned Depth = rcdj_pkg::GapDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] chunk_x_i,
  input  logic [31:0] chunk_z_i,
  input  logic [63:0] revision_in_i,
  input  logic [63:0] prior_revision_i,
  input  logic [31:0] world_in_i,
  input  logic [63:0] change_data_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [63:0] revision_out_o,
  output logic [63:0] prior_out_o,
  output logic [31:0] world_out_o,
  output logic [63:0] data_out_o,
  output logic        snapshot_needed_o,
  output logic [6:0]  retained_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_capacity_i
);

  localparam int unsigned SlotW  = rcdj_pkg::SlotW;
  localparam int unsigned CountW = rcdj_pkg::CountW;
  localparam logic [CountW-1:0] Slots = CountW'(rcdj_pkg::NumSlots);

  rcdj_pkg::fsm_e state_q, state_d;

  logic [6:0]        cap_q;
  logic [CountW-1:0] count_q;
  logic [SlotW-1:0]  head_q;
  logic [CountW-1:0] iss_q;
  logic              rd_vld_q;
  logic              res_vld_q;

  logic [2:0]  req_q;
  logic [31:0] cx_q, cz_q, world_q;
  logic [63:0] rev_q, prior_q, data_q;
  logic [63:0] lat_q;
  logic        fnd_q;
  logic        lk_q;
  rcdj_pkg::rec_t lk_rec_q;
  logic [CountW-1:0] wcnt_q;
  logic [rcdj_pkg::NumSlots-1:0] bm_q;
  logic [CountW-1:0] gap_q;

  logic [2:0]  status_q;
  logic [63:0] rev_out_q, prior_out_q, data_out_q;
  logic [31:0] world_out_q;
  logic        snap_q;
  logic [6:0]  ret_q;

  rcdj_pkg::rec_t mem_q [rcdj_pkg::NumSlots];
  rcdj_pkg::rec_t rd_q;

  logic              accept, imm, issue, scan_end, fin_scan, fin_link, snap_go;
  logic              hit, keep, link_hit, do_append, mem_we;
  logic [SlotW-1:0]  wa, ra;
  rcdj_pkg::rec_t    wd;
  logic [CountW-1:0] eff_cap;
  logic [63:0]       gap;
  logic [2:0]        imm_status;
  logic [rcdj_pkg::NumSlots-1:0] gap_mask;
  logic [63:0]       off;

  assign eff_cap = (cap_q > 7'(rcdj_pkg::NumSlots)) ? Slots : CountW'(cap_q);

  always_comb begin
    imm        = 1'b1;
    imm_status = rcdj_pkg::ST_OK;
    if (cap_q == 7'd0) begin
      imm_status = rcdj_pkg::ST_NOINIT;
    end else begin
      case (req_type_i)
        rcdj_pkg::REQ_APPEND: begin
          if (revision_in_i == 64'd0 || world_in_i == 32'd0 ||
              revision_in_i <= prior_revision_i) begin
            imm_status = rcdj_pkg::ST_BADARG;
          end else begin
            imm = 1'b0;
          end
        end
        rcdj_pkg::REQ_NEXT: begin
          if (revision_in_i == '1) begin
            imm_status = rcdj_pkg::ST_RANGE;
          end else begin
            imm = 1'b0;
          end
        end
        rcdj_pkg::REQ_LATEST, rcdj_pkg::REQ_PRUNE, rcdj_pkg::REQ_SNAP: imm = 1'b0;
        default: imm_status = rcdj_pkg::ST_BADARG;
      endcase
    end
  end

  assign accept   = start_i && (state_q == rcdj_pkg::FSM_IDLE);
  assign issue    = (state_q != rcdj_pkg::FSM_IDLE) && (iss_q != count_q);
  assign scan_end = (state_q != rcdj_pkg::FSM_IDLE) && (iss_q == count_q) && !rd_vld_q;
  assign fin_scan = scan_end && (state_q == rcdj_pkg::FSM_SCAN);
  assign fin_link = scan_end && (state_q == rcdj_pkg::FSM_LINK);
  assign gap      = lat_q - rev_q;
  assign snap_go  = fin_scan && (req_q == rcdj_pkg::REQ_SNAP) && fnd_q && (rev_q < lat_q) &&
                    (gap <= 64'(Depth)) && (gap <= 64'(rcdj_pkg::NumSlots));

  assign hit      = rd_vld_q && (rd_q.chunk_x == cx_q) && (rd_q.chunk_z == cz_q);
  assign keep     = !(hit && (rd_q.revision <= rev_q));
  assign link_hit = hit && (rd_q.prior == rev_q) && (rd_q.revision == rev_q + 64'd1);
  assign off      = rd_q.prior - rev_q;

  assign do_append = fin_scan && (req_q == rcdj_pkg::REQ_APPEND) &&
                     !(fnd_q && (lat_q != prior_q));

  always_comb begin
    mem_we = 1'b0;
    wa     = head_q + count_q[SlotW-1:0];
    wd     = '{chunk_x: cx_q, chunk_z: cz_q, revision: rev_q, prior: prior_q,
               world: world_q, data: data_q};
    if (do_append) begin
      mem_we = 1'b1;
    end else if (state_q == rcdj_pkg::FSM_SCAN && req_q == rcdj_pkg::REQ_PRUNE &&
                 rd_vld_q && keep) begin
      mem_we = 1'b1;
      wa     = head_q + wcnt_q[SlotW-1:0];
      wd     = rd_q;
    end
  end

  assign ra = head_q + iss_q[SlotW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rcdj_pkg::FSM_IDLE: if (accept && !imm) state_d = rcdj_pkg::FSM_SCAN;
      rcdj_pkg::FSM_SCAN: begin
        if (scan_end) state_d = snap_go ? rcdj_pkg::FSM_LINK : rcdj_pkg::FSM_IDLE;
      end
      rcdj_pkg::FSM_LINK: if (scan_end) state_d = rcdj_pkg::FSM_IDLE;
      default: state_d = rcdj_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    if (gap_q >= Slots) begin
      gap_mask = '1;
    end else begin
      gap_mask = ({{(rcdj_pkg::NumSlots-1){1'b0}}, 1'b1} << gap_q[SlotW-1:0]) -
                 rcdj_pkg::NumSlots'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rcdj_pkg::FSM_IDLE;
      cap_q     <= '0;
      count_q   <= '0;
      head_q    <= '0;
      iss_q     <= '0;
      rd_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= issue;
      res_vld_q <= (accept && imm) || (fin_scan && !snap_go) || fin_link;
      if (state_q == rcdj_pkg::FSM_IDLE || snap_go) begin
        iss_q <= '0;
      end else if (issue) begin
        iss_q <= iss_q + CountW'(1);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_capacity_i;
        if (cfg_capacity_i == 7'd0) begin
          count_q <= '0;
        end else if (count_q > ((cfg_capacity_i > 7'(rcdj_pkg::NumSlots)) ? Slots
                                : CountW'(cfg_capacity_i))) begin
          head_q  <= head_q + SlotW'(count_q - CountW'(cfg_capacity_i));
          count_q <= CountW'(cfg_capacity_i);
        end
      end else if (do_append) begin
        if (count_q >= eff_cap) begin
          head_q <= head_q + SlotW'(1);
        end else begin
          count_q <= count_q + CountW'(1);
        end
      end else if (fin_scan && req_q == rcdj_pkg::REQ_PRUNE) begin
        count_q <= wcnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      cx_q    <= chunk_x_i;
      cz_q    <= chunk_z_i;
      rev_q   <= revision_in_i;
      prior_q <= prior_revision_i;
      world_q <= world_in_i;
      data_q  <= change_data_i;
      fnd_q   <= 1'b0;
      lat_q   <= '0;
      lk_q    <= 1'b0;
      wcnt_q  <= '0;
      bm_q    <= '0;
    end else if (state_q == rcdj_pkg::FSM_SCAN) begin
      if (hit && (!fnd_q || rd_q.revision > lat_q)) begin
        lat_q <= rd_q.revision;
        fnd_q <= 1'b1;
      end
      if (link_hit && !lk_q) begin
        lk_q     <= 1'b1;
        lk_rec_q <= rd_q;
      end
      if (rd_vld_q && keep) begin
        wcnt_q <= wcnt_q + CountW'(1);
      end
      if (snap_go) begin
        gap_q <= CountW'(gap);
      end
    end else if (state_q == rcdj_pkg::FSM_LINK) begin
      if (hit && (rd_q.revision == rd_q.prior + 64'd1) && (rd_q.prior >= rev_q) &&
          (rd_q.prior < lat_q)) begin
        bm_q[off[SlotW-1:0]] <= 1'b1;
      end
    end

    status_q    <= rcdj_pkg::ST_OK;
    rev_out_q   <= '0;
    prior_out_q <= '0;
    world_out_q <= '0;
    data_out_q  <= '0;
    snap_q      <= 1'b0;
    ret_q       <= 7'(count_q);
    if (accept && imm) begin
      status_q <= imm_status;
    end else if (fin_link) begin
      snap_q <= |(~bm_q & gap_mask);
    end else if (fin_scan) begin
      case (req_q)
        rcdj_pkg::REQ_APPEND: begin
          if (!do_append) begin
            status_q <= rcdj_pkg::ST_BADSTATE;
          end else if (count_q < eff_cap) begin
            ret_q <= 7'(count_q + CountW'(1));
          end
        end
        rcdj_pkg::REQ_LATEST: begin
          if (fnd_q) begin
            rev_out_q <= lat_q;
          end else begin
            status_q <= rcdj_pkg::ST_NOTFOUND;
          end
        end
        rcdj_pkg::REQ_NEXT: begin
          if (lk_q) begin
            rev_out_q   <= lk_rec_q.revision;
            prior_out_q <= lk_rec_q.prior;
            world_out_q <= lk_rec_q.world;
            data_out_q  <= lk_rec_q.data;
          end else begin
            status_q <= rcdj_pkg::ST_NOTFOUND;
          end
        end
        rcdj_pkg::REQ_PRUNE: ret_q <= 7'(wcnt_q);
        rcdj_pkg::REQ_SNAP:  snap_q <= fnd_q && (rev_q < lat_q);
        default: status_q <= rcdj_pkg::ST_BADARG;
      endcase
    end
  end

  assign busy_o            = (state_q != rcdj_pkg::FSM_IDLE);
  assign cfg_ready_o       = (state_q == rcdj_pkg::FSM_IDLE) && !start_i;
  assign done_o            = res_vld_q;
  assign status_o          = status_q;
  assign revision_out_o    = rev_out_q;
  assign prior_out_o       = prior_out_q;
  assign world_out_o       = world_out_q;
  assign data_out_o        = data_out_q;
  assign snapshot_needed_o = snap_q;
  assign retained_o        = ret_q;

  `RCDJ_ASSERT(count_bounded_a, count_q <= Slots)
  `RCDJ_ASSERT(read_in_pass_a, rd_vld_q |-> (state_q == rcdj_pkg::FSM_SCAN ||
                                             state_q == rcdj_pkg::FSM_LINK))
  `RCDJ_ASSERT(prune_write_behind_a, (state_q == rcdj_pkg::FSM_SCAN) |-> (wcnt_q <= iss_q))
  `RCDJ_ASSERT_ALWAYS(count_within_cap_a, rst_ni |-> (count_q <= eff_cap))

endmodule
